FILE: sv/sm83r0_pkg.sv
// ----------------------------------------------------------------------------
// sm83r0_pkg: shared types for the SM83 row-0 opcode execute block
// Payload structs for both channels and the decoded micro-op that runs
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sm83r0_pkg;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [15:0] immediate;
    logic [7:0]  mem_read_byte;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_addr;
    logic [7:0]  write_byte;
    logic        last;
    logic        illegal;
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
    logic [15:0] bc_out;
    logic [15:0] hl_out;
    logic [1:0]  length_bytes;
    logic [4:0]  clock_cycles;
  } out_t;

  typedef enum logic [3:0] {
    K_NOP,
    K_LD_BC_IMM,
    K_ST_BC_A,
    K_INC_BC,
    K_DEC_BC,
    K_INC_R8,
    K_DEC_R8,
    K_LD_R8_IMM,
    K_RLCA,
    K_RRCA,
    K_ST_SP,
    K_ADD_HL_BC,
    K_LD_A_BC,
    K_ILLEGAL
  } op_kind_t;

  // Decoded instruction as it waits in the queue.
  typedef struct packed {
    op_kind_t    kind;
    logic        sel_c;      // 8-bit operand is C rather than B
    logic [1:0]  len;
    logic [4:0]  cycles;
    logic [15:0] imm;
    logic [7:0]  mem;
  } uop_t;

  localparam logic [15:0] SP_RESET = 16'hFFFE;

endpackage

FILE: sv/sm83_opcode_row0_execute.sv
// ----------------------------------------------------------------------------
// sm83_opcode_row0_execute: SM83 opcodes 0x00-0x0F execute unit
// Each input word carries an opcode, its fetched immediate and the memory
// byte at BC. The block runs it against A, F, B, C, HL and SP and returns
// one result word (two for LD (a16),SP: low byte, then high byte at the
// following address). Other opcodes return one word flagged illegal.
// Both channels are valid/ready; a word moves when valid and ready are high.
// An accepted input is registered in the queue, then in the result register.
// Throughput: one opcode per cycle while the receiver is ready; LD (a16),SP
// holds the execute stage until its high-byte word has gone into the single
// result register that both its words use.
// A queue of QUEUE_DEPTH decoded opcodes sits between decode and execute,
// so input keeps being accepted while the receiver stalls until the queue
// and the result register are full; a stalled result word holds steady.
// Reset (rst, synchronous) clears A, F, B, C, HL to zero, sets SP to
// 0xFFFE and empties the queue and result register.
// ----------------------------------------------------------------------------
module sm83_opcode_row0_execute #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sm83r0_pkg::in_t  item,
  output logic             result_valid,
  input  logic             result_ready,
  output sm83r0_pkg::out_t result
);

  logic             dec_valid;
  logic             dec_ready;
  sm83r0_pkg::uop_t dec_uop;
  logic             exe_valid;
  logic             exe_ready;
  sm83r0_pkg::uop_t exe_uop;

  sm83r0_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .uop_valid  (dec_valid),
    .uop_ready  (dec_ready),
    .uop        (dec_uop)
  );

  sm83r0_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_data  (dec_uop),
    .pop_valid  (exe_valid),
    .pop_ready  (exe_ready),
    .pop_data   (exe_uop)
  );

  sm83r0_back u_back (
    .clk          (clk),
    .rst          (rst),
    .uop_valid    (exe_valid),
    .uop_ready    (exe_ready),
    .uop          (exe_uop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: sv/sm83r0_front.sv
// ----------------------------------------------------------------------------
// sm83r0_front: opcode decode
// Classifies each incoming opcode into a micro-op kind and attaches the
// length and cycle count from the decode table.
// ----------------------------------------------------------------------------
module sm83r0_front (
  input  logic             item_valid,
  output logic             item_ready,
  input  sm83r0_pkg::in_t  item,
  output logic             uop_valid,
  input  logic             uop_ready,
  output sm83r0_pkg::uop_t uop
);

  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
  localparam logic [7:0] OP_LD_BC_A   = 8'h02;
  localparam logic [7:0] OP_INC_BC    = 8'h03;
  localparam logic [7:0] OP_INC_B     = 8'h04;
  localparam logic [7:0] OP_DEC_B     = 8'h05;
  localparam logic [7:0] OP_LD_B_D8   = 8'h06;
  localparam logic [7:0] OP_RLCA      = 8'h07;
  localparam logic [7:0] OP_LD_A16_SP = 8'h08;
  localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
  localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
  localparam logic [7:0] OP_DEC_BC    = 8'h0B;
  localparam logic [7:0] OP_INC_C     = 8'h0C;
  localparam logic [7:0] OP_DEC_C     = 8'h0D;
  localparam logic [7:0] OP_LD_C_D8   = 8'h0E;
  localparam logic [7:0] OP_RRCA      = 8'h0F;

  assign uop_valid  = item_valid;
  assign item_ready = uop_ready;

  always_comb begin
    uop.imm   = item.immediate;
    uop.mem   = item.mem_read_byte;
    uop.sel_c = 1'b0;
    unique case (item.cmd)
      OP_NOP: begin
        uop.kind = sm83r0_pkg::K_NOP;       uop.len = 2'd1; uop.cycles = 5'd4;
      end
      OP_LD_BC_D16: begin
        uop.kind = sm83r0_pkg::K_LD_BC_IMM; uop.len = 2'd3; uop.cycles = 5'd12;
      end
      OP_LD_BC_A: begin
        uop.kind = sm83r0_pkg::K_ST_BC_A;   uop.len = 2'd1; uop.cycles = 5'd8;
      end
      OP_INC_BC: begin
        uop.kind = sm83r0_pkg::K_INC_BC;    uop.len = 2'd1; uop.cycles = 5'd8;
      end
      OP_INC_B: begin
        uop.kind = sm83r0_pkg::K_INC_R8;    uop.len = 2'd1; uop.cycles = 5'd4;
      end
      OP_DEC_B: begin
        uop.kind = sm83r0_pkg::K_DEC_R8;    uop.len = 2'd1; uop.cycles = 5'd4;
      end
      OP_LD_B_D8: begin
        uop.kind = sm83r0_pkg::K_LD_R8_IMM; uop.len = 2'd2; uop.cycles = 5'd8;
      end
      OP_RLCA: begin
        uop.kind = sm83r0_pkg::K_RLCA;      uop.len = 2'd1; uop.cycles = 5'd4;
      end
      OP_LD_A16_SP: begin
        uop.kind = sm83r0_pkg::K_ST_SP;     uop.len = 2'd3; uop.cycles = 5'd20;
      end
      OP_ADD_HL_BC: begin
        uop.kind = sm83r0_pkg::K_ADD_HL_BC; uop.len = 2'd1; uop.cycles = 5'd8;
      end
      OP_LD_A_BC: begin
        uop.kind = sm83r0_pkg::K_LD_A_BC;   uop.len = 2'd1; uop.cycles = 5'd8;
      end
      OP_DEC_BC: begin
        uop.kind = sm83r0_pkg::K_DEC_BC;    uop.len = 2'd1; uop.cycles = 5'd8;
      end
      OP_INC_C: begin
        uop.kind = sm83r0_pkg::K_INC_R8;    uop.len = 2'd1; uop.cycles = 5'd4;
        uop.sel_c = 1'b1;
      end
      OP_DEC_C: begin
        uop.kind = sm83r0_pkg::K_DEC_R8;    uop.len = 2'd1; uop.cycles = 5'd4;
        uop.sel_c = 1'b1;
      end
      OP_LD_C_D8: begin
        uop.kind = sm83r0_pkg::K_LD_R8_IMM; uop.len = 2'd2; uop.cycles = 5'd8;
        uop.sel_c = 1'b1;
      end
      OP_RRCA: begin
        uop.kind = sm83r0_pkg::K_RRCA;      uop.len = 2'd1; uop.cycles = 5'd4;
      end
      default: begin
        uop.kind = sm83r0_pkg::K_ILLEGAL;   uop.len = 2'd1; uop.cycles = 5'd0;
      end
    endcase
  end

endmodule

FILE: sv/sm83r0_queue.sv
// ----------------------------------------------------------------------------
// sm83r0_queue: micro-op queue
// Small circular buffer between decode and execute so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module sm83r0_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sm83r0_pkg::uop_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sm83r0_pkg::uop_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sm83r0_pkg::uop_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/sm83r0_back.sv
// ----------------------------------------------------------------------------
// sm83r0_back: execute stage and result register
// Holds the register file and emits result words, one micro-op per cycle
// unless output stalls or the two-byte SP store still owes its high byte.
// ----------------------------------------------------------------------------
module sm83r0_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             uop_valid,
  output logic             uop_ready,
  input  sm83r0_pkg::uop_t uop,
  output logic             result_valid,
  input  logic             result_ready,
  output sm83r0_pkg::out_t result
);

  logic [7:0]  acc;
  logic [3:0]  flags;        // Z N H C
  logic [7:0]  reg_b;
  logic [7:0]  reg_c;
  logic [15:0] reg_hl;
  logic [15:0] stack_ptr;

  logic [7:0]  acc_next;
  logic [3:0]  flags_next;
  logic [7:0]  reg_b_next;
  logic [7:0]  reg_c_next;
  logic [15:0] reg_hl_next;

  // Second half of LD (a16),SP waiting to go out.
  logic        pending;
  logic [15:0] pend_addr;
  logic [1:0]  pend_len;
  logic [4:0]  pend_cycles;

  logic        load;
  logic        take;
  logic [15:0] bc;
  logic [15:0] bc_step;
  logic [7:0]  r8;
  logic [7:0]  r8_step;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  sm83r0_pkg::out_t result_next;

  assign load      = !result_valid || result_ready;
  assign uop_ready = load && !pending;
  assign take      = uop_valid && uop_ready;

  assign bc      = {reg_b, reg_c};
  assign bc_step = (uop.kind == sm83r0_pkg::K_INC_BC) ? bc + 16'd1 : bc - 16'd1;
  assign r8      = uop.sel_c ? reg_c : reg_b;
  assign r8_step = (uop.kind == sm83r0_pkg::K_INC_R8) ? r8 + 8'd1 : r8 - 8'd1;
  assign hl_sum  = {1'b0, reg_hl} + {1'b0, bc};
  assign hl_half = {1'b0, reg_hl[11:0]} + {1'b0, bc[11:0]};

  always_comb begin
    acc_next    = acc;
    flags_next  = flags;
    reg_b_next  = reg_b;
    reg_c_next  = reg_c;
    reg_hl_next = reg_hl;
    unique case (uop.kind)
      sm83r0_pkg::K_LD_BC_IMM: begin
        reg_b_next = uop.imm[15:8];
        reg_c_next = uop.imm[7:0];
      end
      sm83r0_pkg::K_INC_BC, sm83r0_pkg::K_DEC_BC: begin
        reg_b_next = bc_step[15:8];
        reg_c_next = bc_step[7:0];
      end
      sm83r0_pkg::K_INC_R8: begin
        flags_next = {r8_step == 8'd0, 1'b0, r8[3:0] == 4'hF, flags[0]};
        if (uop.sel_c) reg_c_next = r8_step;
        else reg_b_next = r8_step;
      end
      sm83r0_pkg::K_DEC_R8: begin
        flags_next = {r8_step == 8'd0, 1'b1, r8[3:0] == 4'h0, flags[0]};
        if (uop.sel_c) reg_c_next = r8_step;
        else reg_b_next = r8_step;
      end
      sm83r0_pkg::K_LD_R8_IMM: begin
        if (uop.sel_c) reg_c_next = uop.imm[7:0];
        else reg_b_next = uop.imm[7:0];
      end
      sm83r0_pkg::K_RLCA: begin
        acc_next   = {acc[6:0], acc[7]};
        flags_next = {3'b000, acc[7]};
      end
      sm83r0_pkg::K_RRCA: begin
        acc_next   = {acc[0], acc[7:1]};
        flags_next = {3'b000, acc[0]};
      end
      sm83r0_pkg::K_ADD_HL_BC: begin
        flags_next  = {flags[3], 1'b0, hl_half[12], hl_sum[16]};
        reg_hl_next = hl_sum[15:0];
      end
      sm83r0_pkg::K_LD_A_BC: begin
        acc_next = uop.mem;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_next.write_enable = 1'b0;
    result_next.write_addr   = 16'd0;
    result_next.write_byte   = 8'd0;
    result_next.last         = 1'b1;
    result_next.illegal      = 1'b0;
    result_next.length_bytes = uop.len;
    result_next.clock_cycles = uop.cycles;
    result_next.acc_out      = acc_next;
    result_next.flags_out    = {flags_next, 4'b0000};
    result_next.bc_out       = {reg_b_next, reg_c_next};
    result_next.hl_out       = reg_hl_next;
    if (pending) begin
      result_next.write_enable = 1'b1;
      result_next.write_addr   = pend_addr;
      result_next.write_byte   = stack_ptr[15:8];
      result_next.length_bytes = pend_len;
      result_next.clock_cycles = pend_cycles;
      result_next.acc_out      = acc;
      result_next.flags_out    = {flags, 4'b0000};
      result_next.bc_out       = bc;
      result_next.hl_out       = reg_hl;
    end else if (uop.kind == sm83r0_pkg::K_ST_SP) begin
      result_next.write_enable = 1'b1;
      result_next.write_addr   = uop.imm;
      result_next.write_byte   = stack_ptr[7:0];
      result_next.last         = 1'b0;
    end else if (uop.kind == sm83r0_pkg::K_ST_BC_A) begin
      result_next.write_enable = 1'b1;
      result_next.write_addr   = bc;
      result_next.write_byte   = acc;
    end else if (uop.kind == sm83r0_pkg::K_ILLEGAL) begin
      result_next.illegal = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= 8'd0;
      flags        <= 4'd0;
      reg_b        <= 8'd0;
      reg_c        <= 8'd0;
      reg_hl       <= 16'd0;
      stack_ptr    <= sm83r0_pkg::SP_RESET;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        acc    <= acc_next;
        flags  <= flags_next;
        reg_b  <= reg_b_next;
        reg_c  <= reg_c_next;
        reg_hl <= reg_hl_next;
        pending <= (uop.kind == sm83r0_pkg::K_ST_SP);
      end else if (load && pending) begin
        pending <= 1'b0;
      end
      if (load) begin
        result_valid <= take || pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_addr   <= uop.imm + 16'd1;
      pend_len    <= uop.len;
      pend_cycles <= uop.cycles;
    end
    if (take || (load && pending)) begin
      result <= result_next;
    end
  end

  a_pending_shows: assert property (@(posedge clk) disable iff (rst)
    pending |-> result_valid && !result.last && result.write_enable)
    else $error("store high byte pending without its low-byte word on output");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    pending && result_ready |=> result_valid && result.last && result.write_enable)
    else $error("high-byte word did not follow the low-byte word");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.illegal |-> !result.write_enable && result.last)
    else $error("illegal opcode produced a write");

  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    pending |-> !uop_ready)
    else $error("new micro-op taken during two-byte store");

endmodule
